[design/slme_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package slme_pkg;

	typedef enum logic [1:0] {
		CMD_APPEND_FIRST  = 2'd0,
		CMD_APPEND_SECOND = 2'd1,
		CMD_MERGE         = 2'd2,
		CMD_DUMP          = 2'd3
	} cmd_e;

	localparam logic [1:0] KIND_STATUS  = 2'd0;
	localparam logic [1:0] KIND_ELEMENT = 2'd1;
	localparam logic [1:0] KIND_EMPTY   = 2'd2;

	localparam logic [1:0] ST_DONE      = 2'd0;
	localparam logic [1:0] ST_FULL      = 2'd1;
	localparam logic [1:0] ST_NO_MERGE  = 2'd2;

	typedef struct packed {
		logic [1:0]         cmd;
		logic signed [31:0] value;
	} req_t;

	typedef struct packed {
		logic [1:0]         kind;
		logic               list_id;
		logic signed [31:0] element;
		logic [1:0]         status;
		logic               last;
	} res_t;

	// Queued request from the front part to the back part.
	typedef struct packed {
		logic [1:0]         cmd;
		logic signed [31:0] value;
	} job_t;

endpackage
`default_nettype wire

[design/sorted_list_merge_engine_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// Two-way merge engine for two lists of signed 32-bit values kept in a pool of
// POOL_SIZE entries. A request is taken when start is high and busy is low;
// busy stays high until the request's final result (last set) has been shown.
// Each result appears on result for exactly one cycle with done high, and the
// receiver must take it then, since the block never waits. An append or a
// refused merge is answered straight from the idle state; a merge runs a compare
// pass then a copy back, paced by the registered list memory reads; a dump
// gives its results one by one, each after a wait state for the memory read.
module sorted_list_merge_engine_core #(
	parameter int POOL_SIZE = 32
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            start,
	output logic                 busy,
	input  wire slme_pkg::req_t  req,
	output logic                 done,
	output slme_pkg::res_t       result
);

	logic           job_valid;
	logic           job_take;
	slme_pkg::job_t job;

	slme_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.req       (req),
		.job_valid (job_valid),
		.job       (job),
		.job_take  (job_take)
	);

	slme_back #(.POOL_SIZE(POOL_SIZE)) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.job_valid    (job_valid),
		.job          (job),
		.job_take     (job_take),
		.result_valid (done),
		.result       (result)
	);

endmodule
`default_nettype wire

[design/slme_front.sv]
`timescale 1ns / 1ps
`default_nettype none
module slme_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	output logic               busy,
	input  wire slme_pkg::req_t req,
	output logic               job_valid,
	output slme_pkg::job_t     job,
	input  wire logic          job_take
);

	// Two-entry queue that decouples request capture from execution.
	slme_pkg::job_t q_mem_q [2];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     cnt_q;
	logic           push;
	logic           pop;
	logic           job_busy_q;
	logic           job_take_done;

	// One request in flight: hold further requests while any is queued or running.
	assign busy      = (cnt_q != 2'd0) || job_busy_q;
	assign push      = start && !busy;
	assign job_valid = (cnt_q != 2'd0);
	assign pop       = job_valid && job_take;
	assign job       = q_mem_q[rd_ptr_q];

	// The back part is idle again when it asks for the next job.
	assign job_take_done = job_take && !job_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q   <= 1'b0;
			rd_ptr_q   <= 1'b0;
			cnt_q      <= 2'd0;
			job_busy_q <= 1'b0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
			if (pop) begin
				job_busy_q <= 1'b1;
			end else if (job_take_done) begin
				job_busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem_q[wr_ptr_q] <= slme_pkg::job_t'{cmd: req.cmd, value: req.value};
		end
	end

`ifndef SYNTH
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= 2'd2)
		else $error("queue count overflow");
	a_no_push_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !push) else $error("push while busy");
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> cnt_q != 2'd0) else $error("pop from empty queue");
`endif

endmodule
`default_nettype wire

[design/slme_back.sv]
`timescale 1ns / 1ps
`default_nettype none
module slme_back #(
	parameter int POOL_SIZE = 32
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           job_valid,
	input  wire slme_pkg::job_t job,
	output logic                job_take,
	output logic                result_valid,
	output slme_pkg::res_t      result
);

	localparam int AW = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
	localparam int CW = $clog2(POOL_SIZE + 1);
	localparam logic [CW:0] POOL_N = (CW + 1)'(POOL_SIZE);

	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_MREAD = 7'b0000010,
		S_MCMP  = 7'b0000100,
		S_COPY  = 7'b0001000,
		S_COPYW = 7'b0010000,
		S_DUMP  = 7'b0100000,
		S_DUMPW = 7'b1000000
	} state_e;

	state_e state_q;

	logic [31:0] first_mem  [POOL_SIZE];
	logic [31:0] second_mem [POOL_SIZE];
	logic [31:0] scratch_mem[POOL_SIZE];

	logic [CW-1:0] first_cnt_q, second_cnt_q;
	logic [CW-1:0] i_q, j_q, n_q;
	logic          lst_q;
	logic [31:0]   rd_a_q, rd_b_q, rd_s_q;

	logic          a_left, b_left;
	assign a_left = (i_q < first_cnt_q);
	assign b_left = (j_q < second_cnt_q);

	// Signed compare, first list wins on ties.
	logic take_a;
	assign take_a = a_left && (!b_left || ($signed(rd_a_q) <= $signed(rd_b_q)));

	assign job_take = (state_q == S_IDLE);

	// Memory ports.
	logic          fw_en, sw_en, xw_en;
	logic [AW-1:0] fw_addr, sw_addr, xw_addr;
	logic [31:0]   fw_data, sw_data, xw_data;
	logic [AW-1:0] fr_addr, sr_addr, xr_addr;

	always_ff @(posedge clk) begin
		if (fw_en) first_mem[fw_addr]    <= fw_data;
		if (sw_en) second_mem[sw_addr]   <= sw_data;
		if (xw_en) scratch_mem[xw_addr]  <= xw_data;
		rd_a_q <= first_mem[fr_addr];
		rd_b_q <= second_mem[sr_addr];
		rd_s_q <= scratch_mem[xr_addr];
	end

	logic [CW-1:0] total;
	assign total = first_cnt_q + second_cnt_q;

	always_comb begin
		fw_en   = 1'b0;
		sw_en   = 1'b0;
		xw_en   = 1'b0;
		fw_addr = first_cnt_q[AW-1:0];
		sw_addr = second_cnt_q[AW-1:0];
		xw_addr = n_q[AW-1:0];
		fw_data = job.value;
		sw_data = job.value;
		xw_data = take_a ? rd_a_q : rd_b_q;
		fr_addr = i_q[AW-1:0];
		sr_addr = j_q[AW-1:0];
		xr_addr = n_q[AW-1:0];
		case (state_q)
			S_IDLE: begin
				if (job_valid && ({1'b0, total} < POOL_N)) begin
					fw_en = (job.cmd == slme_pkg::CMD_APPEND_FIRST);
					sw_en = (job.cmd == slme_pkg::CMD_APPEND_SECOND);
				end
				fr_addr = '0;
				sr_addr = '0;
				xr_addr = '0;
			end
			S_MCMP: begin
				xw_en = 1'b1;
				if (take_a) fr_addr = AW'(i_q + 1'b1);
				else        sr_addr = AW'(j_q + 1'b1);
			end
			S_COPYW: begin
				fw_en   = 1'b1;
				fw_addr = n_q[AW-1:0];
				fw_data = rd_s_q;
				xr_addr = AW'(n_q + 1'b1);
			end
			default: ;
		endcase
	end

	logic [CW-1:0] cnt_cur;
	assign cnt_cur = lst_q ? second_cnt_q : first_cnt_q;
	logic [CW-1:0] idx_cur;
	assign idx_cur = lst_q ? j_q : i_q;

	always_ff @(posedge clk or negedge arst_n) begin
		slme_pkg::res_t res_n;
		logic           vld_n;
		if (!arst_n) begin
			state_q      <= S_IDLE;
			first_cnt_q  <= '0;
			second_cnt_q <= '0;
			i_q          <= '0;
			j_q          <= '0;
			n_q          <= '0;
			lst_q        <= 1'b0;
			result_valid <= 1'b0;
			result       <= '0;
		end else begin
			vld_n = 1'b0;
			res_n = '0;
			case (state_q)
				S_IDLE: begin
					i_q   <= '0;
					j_q   <= '0;
					n_q   <= '0;
					lst_q <= 1'b0;
					if (job_valid) begin
						case (job.cmd)
							slme_pkg::CMD_APPEND_FIRST, slme_pkg::CMD_APPEND_SECOND: begin
								vld_n      = 1'b1;
								res_n.last = 1'b1;
								if ({1'b0, total} >= POOL_N) begin
									res_n.status = slme_pkg::ST_FULL;
								end else if (job.cmd == slme_pkg::CMD_APPEND_FIRST) begin
									first_cnt_q <= first_cnt_q + 1'b1;
								end else begin
									second_cnt_q <= second_cnt_q + 1'b1;
								end
							end
							slme_pkg::CMD_MERGE: begin
								if (first_cnt_q == '0 || second_cnt_q == '0) begin
									vld_n        = 1'b1;
									res_n.last   = 1'b1;
									res_n.status = slme_pkg::ST_NO_MERGE;
								end else begin
									state_q <= S_MREAD;
								end
							end
							default: state_q <= S_DUMPW;
						endcase
					end
				end
				S_MREAD: state_q <= S_MCMP;
				S_MCMP: begin
					if (take_a) i_q <= i_q + 1'b1;
					else        j_q <= j_q + 1'b1;
					// The copy pass restarts from the head of the scratch list.
					if (n_q + 1'b1 == total) begin
						n_q     <= '0;
						state_q <= S_COPY;
					end else begin
						n_q     <= n_q + 1'b1;
						state_q <= S_MREAD;
					end
				end
				S_COPY: begin
					state_q <= S_COPYW;
				end
				S_COPYW: begin
					n_q <= n_q + 1'b1;
					if (n_q + 1'b1 == total) begin
						first_cnt_q  <= total;
						second_cnt_q <= '0;
						vld_n        = 1'b1;
						res_n.last   = 1'b1;
						res_n.status = slme_pkg::ST_DONE;
						state_q      <= S_IDLE;
					end else begin
						state_q <= S_COPY;
					end
				end
				S_DUMPW: state_q <= S_DUMP;
				S_DUMP: begin
					vld_n         = 1'b1;
					res_n.list_id = lst_q;
					if (cnt_cur == '0) begin
						res_n.kind = slme_pkg::KIND_EMPTY;
					end else begin
						res_n.kind    = slme_pkg::KIND_ELEMENT;
						res_n.element = lst_q ? rd_b_q : rd_a_q;
					end
					if (cnt_cur == '0 || idx_cur + 1'b1 >= cnt_cur) begin
						if (lst_q) begin
							res_n.last = 1'b1;
							state_q    <= S_IDLE;
						end else begin
							lst_q   <= 1'b1;
							state_q <= S_DUMPW;
						end
					end else begin
						if (lst_q) j_q <= j_q + 1'b1;
						else       i_q <= i_q + 1'b1;
						state_q <= S_DUMPW;
					end
				end
				default: state_q <= S_IDLE;
			endcase
			result_valid <= vld_n;
			result       <= res_n;
		end
	end

`ifndef SYNTH
	a_total: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, total} <= POOL_N) else $error("pool overcommitted");
	a_merge_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_COPYW && n_q + 1'b1 == total) |=> second_cnt_q == '0)
		else $error("second list not emptied after merge");
	a_idle_res: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.last) |-> state_q == S_IDLE)
		else $error("final result while still working");
`endif

endmodule
`default_nettype wire
